@@ design/rnwt_pkg.sv @@
// Shared types and constants of the received number window tracker.
package rnwt_pkg;

   localparam int PN_W    = 62;
   localparam int RANGE_W = 7;

   localparam logic FUNC_CHECK  = 1'b0;
   localparam logic FUNC_RECORD = 1'b1;

   typedef struct packed {
      logic            func;
      logic [PN_W-1:0] packet_number;
   } item_type;

endpackage

@@ design/rnwt_if.sv @@
// Request and response channel interfaces of the window tracker.
interface rnwt_req_if
   import rnwt_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic            func;
   logic [PN_W-1:0] packet_number;

   modport source (output valid, func, packet_number, input ready);
   modport sink   (input valid, func, packet_number, output ready);
endinterface

interface rnwt_rsp_if
   import rnwt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               was_seen;
   logic               any_received;
   logic [PN_W-1:0]    largest_number;
   logic [RANGE_W-1:0] first_range;

   modport source (output valid, was_seen, any_received, largest_number, first_range,
                   input ready);
   modport sink   (input valid, was_seen, any_received, largest_number, first_range,
                   output ready);
endinterface

@@ design/received_number_window_tracker_top.sv @@
// Top level of the received packet number window tracker.
//
// Usage: each item on req_ch carries func (check, or check then record) and
// a 62-bit packet_number. For every item one result leaves on rsp_ch with
// was_seen (number recorded before this item and at most WINDOW below the
// largest), any_received, the largest recorded number and first_range, the
// run of recorded numbers just below the largest (0 to WINDOW).
// Both channels use valid/ready; an item moves when both are high.
// Path from request acceptance to rsp_ch.valid: input register, two-entry
// queue, state update with snapshot register, first-range count into the
// output register.
// Throughput: one item per cycle while rsp_ch.ready is not held low; the
// state update (compare, subtract and window shift) is combinational.
// Reset clears the tracker to nothing received and empties all stages.
// When the receiver holds rsp_ch.ready low the output and snapshot stages
// hold, the queue fills, and req_ch.ready drops once the queue and input
// register are full; no item is lost or repeated.
module received_number_window_tracker_top
   import rnwt_pkg::*;
#(
   parameter int WINDOW = 64
) (
   input  logic        clock,
   input  logic        reset,
   rnwt_req_if.sink    req_ch,
   rnwt_rsp_if.source  rsp_ch
);

   logic     fq_valid, fq_ready;
   item_type fq_item;
   logic     qb_valid, qb_ready;
   item_type qb_item;

   rnwt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (fq_valid),
      .q_ready (fq_ready),
      .q_item  (fq_item)
   );

   rnwt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   rnwt_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (qb_valid),
      .q_ready (qb_ready),
      .q_item  (qb_item),
      .rsp_ch  (rsp_ch)
   );

endmodule

@@ design/rnwt_front.sv @@
// Front stage: registers incoming items and hands them to the queue.
module rnwt_front
   import rnwt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rnwt_req_if.sink    req_ch,
   output logic        q_valid,
   input  logic        q_ready,
   output item_type    q_item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take;

   assign req_ch.ready = !valid_ff || q_ready;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (q_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // keep only the func bit as a record flag, packet number as is
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.func          <= (req_ch.func == FUNC_RECORD);
         item_ff.packet_number <= req_ch.packet_number;
      end
   end

   assign q_valid = valid_ff;
   assign q_item  = item_ff;

endmodule

@@ design/rnwt_queue.sv @@
// Two-entry queue between the front stage and the tracking back end.
module rnwt_queue
   import rnwt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type   mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ design/rnwt_back.sv @@
// Back end: window state update, snapshot stage and first-range output stage.
module rnwt_back
   import rnwt_pkg::*;
#(
   parameter int WINDOW = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  item_type    q_item,
   rnwt_rsp_if.source  rsp_ch
);

   localparam int              IW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [PN_W-1:0] WIN_PN = PN_W'(WINDOW);
   localparam logic [WINDOW-1:0] ONE_W = WINDOW'(1);

   // tracking state
   logic              any_ff, any_in;
   logic [PN_W-1:0]   largest_ff, largest_in;
   logic [WINDOW-1:0] win_ff, win_in;

   // snapshot stage
   logic              s1_v_ff, s1_v_in;
   logic              s1_seen_ff;
   logic              s1_any_ff;
   logic [PN_W-1:0]   s1_largest_ff;
   logic [WINDOW-1:0] s1_win_ff;

   // output stage
   logic               rsp_v_ff, rsp_v_in;
   logic               rsp_seen_ff;
   logic               rsp_any_ff;
   logic [PN_W-1:0]    rsp_largest_ff;
   logic [RANGE_W-1:0] rsp_range_ff;

   logic              pop, s1_ready, s2_ready, s1_move;
   logic [PN_W-1:0]   pn, step, delta;
   logic              above, equal, in_win, seen;
   logic [IW-1:0]     didx, sidx;
   logic [WINDOW-1:0] shifted, old_bit;
   logic [WINDOW-1:0] gaps, lowest_gap;
   logic [RANGE_W-1:0] run_count;

   assign s2_ready = !rsp_v_ff || rsp_ch.ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign q_ready  = s1_ready;
   assign pop      = q_valid && s1_ready;
   assign s1_move  = s1_v_ff && s2_ready;

   assign pn     = q_item.packet_number;
   assign above  = pn > largest_ff;
   assign equal  = pn == largest_ff;
   assign step   = pn - largest_ff;
   assign delta  = largest_ff - pn;
   assign didx   = delta[IW-1:0] - IW'(1);
   assign sidx   = step[IW-1:0] - IW'(1);
   assign in_win = !above && !equal && (delta <= WIN_PN);
   assign seen   = any_ff && (equal || (in_win && win_ff[didx]));

   assign shifted = (step < WIN_PN) ? (win_ff << step[IW-1:0]) : '0;
   assign old_bit = (step <= WIN_PN) ? (ONE_W << sidx) : '0;

   always_comb begin
      any_in     = any_ff;
      largest_in = largest_ff;
      win_in     = win_ff;
      if (pop && q_item.func == FUNC_RECORD) begin
         if (!any_ff) begin
            any_in     = 1'b1;
            largest_in = pn;
         end else if (above) begin
            // slide the window up and mark the old largest
            win_in     = shifted | old_bit;
            largest_in = pn;
         end else if (in_win) begin
            win_in = win_ff | (ONE_W << didx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff     <= 1'b0;
         largest_ff <= '0;
         win_ff     <= '0;
      end else begin
         any_ff     <= any_in;
         largest_ff <= largest_in;
         win_ff     <= win_in;
      end
   end

   always_comb begin
      s1_v_in = s1_v_ff;
      if (pop) begin
         s1_v_in = 1'b1;
      end else if (s1_move) begin
         s1_v_in = 1'b0;
      end
      rsp_v_in = rsp_v_ff;
      if (s1_move) begin
         rsp_v_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_seen_ff    <= seen;
         s1_any_ff     <= any_in;
         s1_largest_ff <= largest_in;
         s1_win_ff     <= win_in;
      end
   end

   // isolate the lowest clear bit, then encode its position
   assign gaps       = ~s1_win_ff;
   assign lowest_gap = gaps & (~gaps + ONE_W);

   always_comb begin
      run_count = '0;
      for (int i = 0; i < WINDOW; i++) begin
         if (lowest_gap[i]) begin
            run_count = run_count | RANGE_W'(i);
         end
      end
      if (gaps == '0) begin
         run_count = RANGE_W'(WINDOW);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_seen_ff    <= s1_seen_ff;
         rsp_any_ff     <= s1_any_ff;
         rsp_largest_ff <= s1_largest_ff;
         rsp_range_ff   <= run_count;
      end
   end

   assign rsp_ch.valid          = rsp_v_ff;
   assign rsp_ch.was_seen       = rsp_seen_ff;
   assign rsp_ch.any_received   = rsp_any_ff;
   assign rsp_ch.largest_number = rsp_largest_ff;
   assign rsp_ch.first_range    = rsp_range_ff;

`ifndef SYNTHESIS
   a_any_sticky: assert property (@(posedge clock) disable iff (reset)
      any_ff |=> any_ff)
      else $error("received flag dropped");

   a_largest_monotonic: assert property (@(posedge clock) disable iff (reset)
      any_ff |=> largest_ff >= $past(largest_ff))
      else $error("largest number went down");

   a_empty_window: assert property (@(posedge clock) disable iff (reset)
      !any_ff |-> win_ff == '0)
      else $error("window bits set before anything was received");

   a_snapshot_hold: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s2_ready |=> s1_v_ff && $stable(s1_largest_ff) && $stable(s1_win_ff))
      else $error("snapshot stage changed while stalled");
`endif

endmodule
